// ===== rtl/tpc_pkg.sv =====
// Shared types, register indexes and constants of the touch pressure calibration block.
package tpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_X_RAW_START   = 3'd0;
  localparam logic [2:0] REG_X_RAW_END     = 3'd1;
  localparam logic [2:0] REG_Y_RAW_START   = 3'd2;
  localparam logic [2:0] REG_Y_RAW_END     = 3'd3;
  localparam logic [2:0] REG_COLUMN_COUNT  = 3'd4;
  localparam logic [2:0] REG_ROW_COUNT     = 3'd5;
  localparam logic [2:0] REG_PRESSURE_LOW  = 3'd6;
  localparam logic [2:0] REG_PRESSURE_HIGH = 3'd7;

  // Register values after reset
  localparam logic [11:0] X_RAW_START_RST   = 12'd3830;
  localparam logic [11:0] X_RAW_END_RST     = 12'd280;
  localparam logic [11:0] Y_RAW_START_RST   = 12'd3870;
  localparam logic [11:0] Y_RAW_END_RST     = 12'd400;
  localparam logic [10:0] COLUMN_COUNT_RST  = 11'd240;
  localparam logic [10:0] ROW_COUNT_RST     = 11'd320;
  localparam logic [15:0] PRESSURE_LOW_RST  = 16'd50;
  localparam logic [15:0] PRESSURE_HIGH_RST = 16'd700;

  // Shared divider operand widths
  localparam int unsigned DIVIDEND_W = 23;
  localparam int unsigned DIVISOR_W  = 12;
  localparam int unsigned DIV_CNT_W  = 5;

  // Product width of the shared multiplier (19 x 11 bits)
  localparam int unsigned MUL_A_W = 19;
  localparam int unsigned MUL_B_W = 11;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Pixel clamp limit set by the field width
  localparam logic [9:0] PIXEL_MAX = 10'd1023;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_AVERAGE,
    ST_P_MUL,
    ST_P_START,
    ST_P_DIV,
    ST_X_MUL,
    ST_X_START,
    ST_X_DIV,
    ST_Y_MUL,
    ST_Y_START,
    ST_Y_DIV,
    ST_FINISH
  } tpc_state_t;

  typedef enum logic [1:0] {
    MUL_PRESSURE,
    MUL_COLUMN,
    MUL_ROW
  } tpc_mul_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         collect;
    logic         average;
    logic         mul_en;
    tpc_mul_sel_t mul_sel;
    logic         div_start;
    logic         div_axis;
    logic         p_take;
    logic         x_take;
    logic         y_take;
    logic         load_out;
  } tpc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_beat;
    logic p_valid;
    logic touch_ok;
    logic div_done;
    logic out_free;
  } tpc_status_t;

endpackage

// ===== rtl/tpc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module tpc_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tpc_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [tpc_pkg::DIVISOR_W-1:0]      divisor,
  output logic [tpc_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                               done
);
  import tpc_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVISOR_W-1:0]  remainder;
  logic [DIVISOR_W:0]    rem_shift;
  logic                  fits;

  // Trial subtraction for the current bit
  always_comb begin
    rem_shift = {remainder, quotient[DIVIDEND_W-1]};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      if (fits) begin
        remainder <= DIVISOR_W'(rem_shift - {1'b0, divisor});
      end else begin
        remainder <= rem_shift[DIVISOR_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/tpc_datapath.sv =====
// Datapath: configuration registers, accumulators, multiplier, divider and result registers.
module tpc_datapath #(
  parameter int unsigned AVG_LOG2 = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tpc_pkg::tpc_cmd_t    cmd,
  output tpc_pkg::tpc_status_t status,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [11:0]          x_sample,
  input  logic [11:0]          y_sample,
  input  logic [7:0]           z1_sample,
  input  logic [7:0]           z2_sample,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           pixel_column,
  output logic [9:0]           pixel_row,
  output logic [14:0]          pressure,
  output logic                 touched
);
  import tpc_pkg::*;

  localparam int unsigned XW    = 12 + AVG_LOG2;
  localparam int unsigned ZW    = 8 + AVG_LOG2;
  localparam int unsigned CNT_W = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVG_LOG2) - 1);

  // Configuration registers
  logic [11:0] x_raw_start, x_raw_end, y_raw_start, y_raw_end;
  logic [10:0] column_count, row_count;
  logic [15:0] pressure_low, pressure_high;

  // Group sums and averages
  logic [XW-1:0]    x_accumulator, y_accumulator;
  logic [ZW-1:0]    z1_accumulator, z2_accumulator;
  logic [CNT_W-1:0] sample_counter;
  logic [11:0]      x_avg, y_avg;
  logic [7:0]       z1_avg, z2_avg;
  logic [MUL_A_W-1:0] x_times_100;
  logic [11:0]      x_avg_calc;

  // Multiplier and divider operands
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [DIVISOR_W-1:0]  den_calc;
  logic                  neg_calc;
  logic [PROD_W-1:0]     product;
  logic [DIVISOR_W-1:0]  den_mag;
  logic                  axis_neg;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic                  div_done;

  // Working results
  logic [14:0] result_pressure;
  logic [9:0]  result_column, result_row;
  logic        result_touched;
  logic        accept;
  logic [15:0] quot_p;

  // Magnitude of a signed axis difference and its sign
  function automatic logic [12:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
    logic [12:0] r;
    if (a >= b) begin
      r = {1'b0, a - b};
    end else begin
      r = {1'b1, b - a};
    end
    return r;
  endfunction

  // Clamp an axis quotient to 0 .. min(count, 1024) - 1, or to 0 when count is zero or the sign is negative
  function automatic logic [9:0] clamp_axis(input logic [DIVIDEND_W-1:0] q,
                                            input logic [10:0] count,
                                            input logic neg);
    logic [9:0] top;
    logic [9:0] r;
    if (count == 11'd0) begin
      top = 10'd0;
    end else if (count > 11'd1024) begin
      top = PIXEL_MAX;
    end else begin
      top = 10'(count - 11'd1);
    end
    if (neg) begin
      r = 10'd0;
    end else if (q > DIVIDEND_W'(top)) begin
      r = top;
    end else begin
      r = q[9:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.collect;
  assign accept    = in_valid && cmd.collect;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_raw_start   <= X_RAW_START_RST;
      x_raw_end     <= X_RAW_END_RST;
      y_raw_start   <= Y_RAW_START_RST;
      y_raw_end     <= Y_RAW_END_RST;
      column_count  <= COLUMN_COUNT_RST;
      row_count     <= ROW_COUNT_RST;
      pressure_low  <= PRESSURE_LOW_RST;
      pressure_high <= PRESSURE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_RAW_START:   x_raw_start   <= cfg_data[11:0];
        REG_X_RAW_END:     x_raw_end     <= cfg_data[11:0];
        REG_Y_RAW_START:   y_raw_start   <= cfg_data[11:0];
        REG_Y_RAW_END:     y_raw_end     <= cfg_data[11:0];
        REG_COLUMN_COUNT:  column_count  <= cfg_data[10:0];
        REG_ROW_COUNT:     row_count     <= cfg_data[10:0];
        REG_PRESSURE_LOW:  pressure_low  <= cfg_data;
        REG_PRESSURE_HIGH: pressure_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Group accumulation; the sums are cleared once they are averaged
  always_ff @(posedge clk) begin
    if (rst) begin
      x_accumulator  <= '0;
      y_accumulator  <= '0;
      z1_accumulator <= '0;
      z2_accumulator <= '0;
      sample_counter <= '0;
    end else if (accept) begin
      x_accumulator  <= x_accumulator + XW'(x_sample);
      y_accumulator  <= y_accumulator + XW'(y_sample);
      z1_accumulator <= z1_accumulator + ZW'(z1_sample);
      z2_accumulator <= z2_accumulator + ZW'(z2_sample);
      if (sample_counter == CNT_LAST) begin
        sample_counter <= '0;
      end else begin
        sample_counter <= sample_counter + 1'b1;
      end
    end else if (cmd.average) begin
      x_accumulator  <= '0;
      y_accumulator  <= '0;
      z1_accumulator <= '0;
      z2_accumulator <= '0;
    end
  end

  // Averages by shifting, and X scaled by one hundred with shifts and adds
  assign x_avg_calc = x_accumulator[XW-1:AVG_LOG2];

  always_ff @(posedge clk) begin
    if (cmd.average) begin
      x_avg       <= x_avg_calc;
      y_avg       <= y_accumulator[XW-1:AVG_LOG2];
      z1_avg      <= z1_accumulator[ZW-1:AVG_LOG2];
      z2_avg      <= z2_accumulator[ZW-1:AVG_LOG2];
      x_times_100 <= {x_avg_calc, 6'd0} + {1'b0, x_avg_calc, 5'd0}
                   + {5'd0, x_avg_calc, 2'd0};
    end
  end

  // Multiplier operand selection and axis denominators
  always_comb begin
    logic [12:0] num_d;
    logic [12:0] den_d;
    mul_a    = x_times_100;
    mul_b    = {3'd0, 8'(z2_avg - z1_avg)};
    den_calc = '0;
    neg_calc = 1'b0;
    num_d    = '0;
    den_d    = '0;
    unique case (cmd.mul_sel)
      MUL_PRESSURE: begin
        mul_a = x_times_100;
      end
      MUL_COLUMN: begin
        num_d    = abs_diff(x_avg, x_raw_start);
        den_d    = abs_diff(x_raw_end, x_raw_start);
        mul_a    = MUL_A_W'(num_d[11:0]);
        mul_b    = column_count;
        den_calc = den_d[11:0];
        neg_calc = num_d[12] ^ den_d[12];
      end
      MUL_ROW: begin
        num_d    = abs_diff(y_avg, y_raw_start);
        den_d    = abs_diff(y_raw_end, y_raw_start);
        mul_a    = MUL_A_W'(num_d[11:0]);
        mul_b    = row_count;
        den_calc = den_d[11:0];
        neg_calc = num_d[12] ^ den_d[12];
      end
      default: ;
    endcase
  end

  // Registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product  <= PROD_W'(mul_a) * PROD_W'(mul_b);
      den_mag  <= den_calc;
      axis_neg <= neg_calc;
    end
  end

  // Pressure divides (x*100*(z2-z1) >> 12) by z1; an axis divides by |end - start|
  assign div_dividend = cmd.div_axis ? product[DIVIDEND_W-1:0]
                                     : DIVIDEND_W'(product[26:12]);
  assign div_divisor  = cmd.div_axis ? den_mag : DIVISOR_W'(z1_avg);

  tpc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Working result registers
  assign quot_p = {1'b0, div_quotient[14:0]};

  always_ff @(posedge clk) begin
    if (cmd.average) begin
      result_pressure <= '0;
      result_column   <= '0;
      result_row      <= '0;
      result_touched  <= 1'b0;
    end else begin
      if (cmd.p_take) begin
        result_pressure <= div_quotient[14:0];
      end
      if (cmd.x_take) begin
        result_column <= clamp_axis(div_quotient, column_count, axis_neg);
      end
      if (cmd.y_take) begin
        result_row     <= clamp_axis(div_quotient, row_count, axis_neg);
        result_touched <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_column <= result_column;
      pixel_row    <= result_row;
      pressure     <= result_pressure;
      touched      <= result_touched;
    end
  end

  // Status towards the controller
  always_comb begin
    status.last_beat = accept && (sample_counter == CNT_LAST);
    status.p_valid   = (z1_avg != 8'd0) && (z2_avg >= z1_avg);
    status.touch_ok  = (quot_p > pressure_low) && (quot_p < pressure_high)
                     && (x_raw_start != x_raw_end) && (y_raw_start != y_raw_end);
    status.div_done  = div_done;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/tpc_controller.sv =====
// Controller state machine that sequences averaging, multiplications and divisions.
module tpc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  tpc_pkg::tpc_status_t status,
  output tpc_pkg::tpc_cmd_t    cmd
);
  import tpc_pkg::*;

  tpc_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (status.last_beat) state_next = ST_AVERAGE;
      ST_AVERAGE: state_next = ST_P_MUL;
      ST_P_MUL:   state_next = status.p_valid ? ST_P_START : ST_FINISH;
      ST_P_START: state_next = ST_P_DIV;
      ST_P_DIV: begin
        if (status.div_done) begin
          state_next = status.touch_ok ? ST_X_MUL : ST_FINISH;
        end
      end
      ST_X_MUL:   state_next = ST_X_START;
      ST_X_START: state_next = ST_X_DIV;
      ST_X_DIV:   if (status.div_done) state_next = ST_Y_MUL;
      ST_Y_MUL:   state_next = ST_Y_START;
      ST_Y_START: state_next = ST_Y_DIV;
      ST_Y_DIV:   if (status.div_done) state_next = ST_FINISH;
      ST_FINISH:  if (status.out_free) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_PRESSURE;
    unique case (state)
      ST_COLLECT: cmd.collect = 1'b1;
      ST_AVERAGE: cmd.average = 1'b1;
      ST_P_MUL:   cmd.mul_en  = 1'b1;
      ST_P_START: cmd.div_start = 1'b1;
      ST_P_DIV:   cmd.p_take  = status.div_done;
      ST_X_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COLUMN;
      end
      ST_X_START: begin
        cmd.div_start = 1'b1;
        cmd.div_axis  = 1'b1;
      end
      ST_X_DIV: begin
        cmd.div_axis = 1'b1;
        cmd.x_take   = status.div_done;
      end
      ST_Y_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ROW;
      end
      ST_Y_START: begin
        cmd.div_start = 1'b1;
        cmd.div_axis  = 1'b1;
      end
      ST_Y_DIV: begin
        cmd.div_axis = 1'b1;
        cmd.y_take   = status.div_done;
      end
      ST_FINISH:  cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/touch_pressure_calibrate_unit.sv =====
// Top level of the resistive touch pressure and calibration block.
//
//   Channel  Handshake            Contents
//   in       in_valid / in_stall   x_sample, y_sample, z1_sample, z2_sample
//   out      out_valid / out_stall pixel_column, pixel_row, pressure, touched
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (ready always high)
//
// Input beats are taken one per cycle until 2^AVG_LOG2 have been summed.
// The group result then skips the shared 23-step divider when Z1 is zero or Z2 is below Z1,
// divides only for pressure when the touch check fails, and also for X and Y on a touch.
// Input is stalled during that work; a result waiting on out_stall holds the block only
// at its final step. Synchronous reset restores the register defaults and empty sums.
module touch_pressure_calibrate_unit #(
  parameter int unsigned AVG_LOG2 = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] x_sample,
  input  logic [11:0] y_sample,
  input  logic [7:0]  z1_sample,
  input  logic [7:0]  z2_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  pixel_column,
  output logic [9:0]  pixel_row,
  output logic [14:0] pressure,
  output logic        touched
);
  import tpc_pkg::*;

  tpc_cmd_t    cmd;
  tpc_status_t status;

  // Sequencing
  tpc_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Arithmetic and storage
  tpc_datapath #(
    .AVG_LOG2 (AVG_LOG2)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_sample     (x_sample),
    .y_sample     (y_sample),
    .z1_sample    (z1_sample),
    .z2_sample    (z2_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .pressure     (pressure),
    .touched      (touched)
  );

endmodule

// ===== rtl/tpc_checker.sv =====
// Port-level checks of the touch pressure calibration block, bound to the top level.
module tpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  pixel_column,
  input logic [9:0]  pixel_row,
  input logic [14:0] pressure,
  input logic        touched
);

  // After reset the block is ready for samples and holds no result.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!in_stall && !out_valid))
    else $error("block not empty after reset");

  // A result beat that is not touched carries zero pixels.
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !touched) |-> (pixel_column == 10'd0 && pixel_row == 10'd0))
    else $error("untouched result with nonzero pixels");

  // A touched result carries a nonzero pressure, as it passed the lower pressure threshold.
  a_touched_pressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && touched) |-> (pressure != 15'd0))
    else $error("touched result with zero pressure");

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pixel_column)
      && $stable(pixel_row) && $stable(pressure) && $stable(touched)))
    else $error("stalled result beat changed");

endmodule

bind touch_pressure_calibrate_unit tpc_checker u_tpc_checker (.*);

// ===== dv/tb_touch_pressure_calibrate_unit.sv =====
// Self-checking testbench for the touch pressure calibration unit: sample beats in, reports out.
`timescale 1ns / 100ps

module tb_touch_pressure_calibrate_unit;
  import tpc_pkg::*;

  localparam int unsigned AVG_LOG2      = 3;
  localparam int unsigned GROUP_LEN     = 1 << AVG_LOG2;
  localparam int unsigned PHASE_COUNT   = 12;
  localparam int unsigned PHASE_GROUPS  = 11;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned MAX_SHOWN     = 10;

  typedef struct packed {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [14:0] pressure;
    logic        touched;
  } touch_report_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BURSTY} stall_pattern_t;

  // Mirror of the calibration registers and group sums, plus the queue of reports to come.
  class calib_scoreboard;
    logic [11:0]   x_start, x_stop, y_start, y_stop;
    logic [10:0]   cols, rows;
    logic [15:0]   press_low, press_high;
    int unsigned   x_sum, y_sum, z1_sum, z2_sum, sets_summed;
    touch_report_t pending_reports[$];
    int unsigned   samples_seen, reports_seen, touches_expected, errors;

    function new();
      x_start          = X_RAW_START_RST;
      x_stop           = X_RAW_END_RST;
      y_start          = Y_RAW_START_RST;
      y_stop           = Y_RAW_END_RST;
      cols             = COLUMN_COUNT_RST;
      rows             = ROW_COUNT_RST;
      press_low        = PRESSURE_LOW_RST;
      press_high       = PRESSURE_HIGH_RST;
      x_sum            = 0;
      y_sum            = 0;
      z1_sum           = 0;
      z2_sum           = 0;
      sets_summed      = 0;
      samples_seen     = 0;
      reports_seen     = 0;
      touches_expected = 0;
      errors           = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [15:0] value);
      case (index)
        REG_X_RAW_START:   x_start    = value[11:0];
        REG_X_RAW_END:     x_stop     = value[11:0];
        REG_Y_RAW_START:   y_start    = value[11:0];
        REG_Y_RAW_END:     y_stop     = value[11:0];
        REG_COLUMN_COUNT:  cols       = value[10:0];
        REG_ROW_COUNT:     rows       = value[10:0];
        REG_PRESSURE_LOW:  press_low  = value;
        REG_PRESSURE_HIGH: press_high = value;
        default: ;
      endcase
    endfunction

    // Two-point linear map, quotient truncated toward zero, then clamped to the display.
    function logic [9:0] map_to_pixel(logic [11:0] raw, logic [11:0] start,
                                      logic [11:0] stop, logic [10:0] count);
      longint r, s, e, n, quotient, limit;
      r = raw;
      s = start;
      e = stop;
      n = count;
      quotient = ((r - s) * n) / (e - s);
      limit = (n > 1024) ? 1024 : n;
      limit = limit - 1;
      if (limit < 0) limit = 0;
      if (quotient < 0) quotient = 0;
      if (quotient > limit) quotient = limit;
      return quotient[9:0];
    endfunction

    // Adds one accepted sample beat; the last beat of a group yields a report.
    function void note_sample(logic [11:0] x, logic [11:0] y, logic [7:0] z1, logic [7:0] z2);
      touch_report_t rep;
      logic [11:0]   x_avg, y_avg;
      logic [7:0]    z1_avg, z2_avg;
      longint        grip;
      samples_seen++;
      x_sum  += x;
      y_sum  += y;
      z1_sum += z1;
      z2_sum += z2;
      if (sets_summed < GROUP_LEN - 1) begin
        sets_summed++;
        return;
      end
      x_avg  = 12'(x_sum >> AVG_LOG2);
      y_avg  = 12'(y_sum >> AVG_LOG2);
      z1_avg = 8'(z1_sum >> AVG_LOG2);
      z2_avg = 8'(z2_sum >> AVG_LOG2);
      x_sum = 0;
      y_sum = 0;
      z1_sum = 0;
      z2_sum = 0;
      sets_summed = 0;
      rep = '0;
      // No contact current or a reversed Z pair leaves the whole report at zero.
      if (z1_avg != 0 && z2_avg >= z1_avg) begin
        grip = (longint'(x_avg) * 100 * longint'(z2_avg - z1_avg)) / (4096 * longint'(z1_avg));
        if (grip > 32767) grip = 32767;
        rep.pressure = grip[14:0];
        if (grip > press_low && grip < press_high && x_start != x_stop && y_start != y_stop) begin
          rep.touched = 1'b1;
          rep.column  = map_to_pixel(x_avg, x_start, x_stop, cols);
          rep.row     = map_to_pixel(y_avg, y_start, y_stop, rows);
          touches_expected++;
        end
      end
      pending_reports.push_back(rep);
    endfunction

    // Compares one accepted report beat with the oldest one pending.
    function void check_report(touch_report_t got);
      touch_report_t want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("ERROR: unexpected report column %0d row %0d pressure %0d touched %0d",
                   got.column, got.row, got.pressure, got.touched);
        return;
      end
      want = pending_reports.pop_front();
      if (got.column !== want.column || got.row !== want.row ||
          got.pressure !== want.pressure || got.touched !== want.touched) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("ERROR: report %0d expected col %0d row %0d p %0d t %0d, got col %0d row %0d p %0d t %0d",
                   reports_seen, want.column, want.row, want.pressure, want.touched,
                   got.column, got.row, got.pressure, got.touched);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] x_sample = '0;
  logic [11:0] y_sample = '0;
  logic [7:0]  z1_sample = '0;
  logic [7:0]  z2_sample = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_X_RAW_START;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  pixel_column;
  logic [9:0]  pixel_row;
  logic [14:0] pressure;
  logic        touched;

  calib_scoreboard board;
  int unsigned     burst_left = 0;
  int unsigned     settings_applied = 0;
  stall_pattern_t  stall_pattern = STALL_NONE;
  int unsigned     stall_left = 0;

  touch_pressure_calibrate_unit #(.AVG_LOG2(AVG_LOG2)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_sample     (x_sample),
    .y_sample     (y_sample),
    .z1_sample    (z1_sample),
    .z2_sample    (z2_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .pressure     (pressure),
    .touched      (touched)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // The receiver stalls on stretches of its own pattern, some with no stall at all.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pattern = stall_pattern_t'($urandom_range(3));
      stall_left = $urandom_range(5, 120);
    end
    stall_left--;
    case (stall_pattern)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(1) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default:     out_stall <= ((stall_left % 40) < 25);
    endcase
  end

  // Every accepted report beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_report(touch_report_t'({pixel_column, pixel_row, pressure, touched}));
  end

  function automatic int wobble(int centre, int spread, int limit);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    return (v < 0) ? 0 : (v > limit) ? limit : v;
  endfunction

  function automatic logic [15:0] with_junk(int unsigned value, int unsigned width);
    return 16'(value) | (16'($urandom) << width);
  endfunction

  // Presents one sample beat and waits until it is taken; bursts end in random gaps.
  task automatic push_sample(input int x, input int y, input int z1, input int z2);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    x_sample  <= 12'(x);
    y_sample  <= 12'(y);
    z1_sample <= 8'(z1);
    z2_sample <= 8'(z2);
    do @(posedge clk); while (in_stall);
    board.note_sample(12'(x), 12'(y), 8'(z1), 8'(z2));
  endtask

  task automatic send_steady_group(input int x, input int y, input int z1, input int z2);
    repeat (GROUP_LEN) push_sample(x, y, z1, z2);
  endtask

  // A group is mostly a steady touch with jitter; some are open plates, reversed Z or noise.
  task automatic send_random_group();
    int x0, y0, z10, z20, spread;
    int unsigned pick;
    pick   = $urandom_range(99);
    x0     = $urandom_range(4095);
    y0     = $urandom_range(4095);
    z10    = $urandom_range(1, 255);
    z20    = $urandom_range(z10, 255);
    spread = $urandom_range(12);
    if (pick < 6)
      z10 = 0;
    else if (pick < 12)
      z20 = $urandom_range(z10 - 1);
    repeat (GROUP_LEN) begin
      if (pick >= 85)
        push_sample($urandom_range(4095), $urandom_range(4095),
                    $urandom_range(255), $urandom_range(255));
      else
        push_sample(wobble(x0, spread, 4095), wobble(y0, spread, 4095),
                    (z10 == 0) ? 0 : wobble(z10, spread, 255), wobble(z20, spread, 255));
    end
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(index, value);
  endtask

  task automatic program_calibration(input logic [15:0] xs, input logic [15:0] xe,
                                     input logic [15:0] ys, input logic [15:0] ye,
                                     input logic [15:0] cc, input logic [15:0] rc,
                                     input logic [15:0] lo, input logic [15:0] hi);
    write_reg(REG_X_RAW_START, xs);
    write_reg(REG_X_RAW_END, xe);
    write_reg(REG_Y_RAW_START, ys);
    write_reg(REG_Y_RAW_END, ye);
    write_reg(REG_COLUMN_COUNT, cc);
    write_reg(REG_ROW_COUNT, rc);
    write_reg(REG_PRESSURE_LOW, lo);
    write_reg(REG_PRESSURE_HIGH, hi);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Lets every pending report out, then gives the divider time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned floor_p;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed groups on the reset calibration: all zero, reversed Z at full scale,
    // and a touch just over the pressure floor with Z2 at full scale.
    send_steady_group(0, 0, 0, 0);
    send_steady_group(4095, 4095, 255, 0);
    send_steady_group(3000, 1234, 150, 255);
    settle();

    for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
      case (phase)
        // Full raw span on both axes, largest display, widest pressure window.
        1: program_calibration(16'd0, 16'd4095, 16'd4095, 16'd0,
                               16'd1024, 16'd1024, 16'd0, 16'd65535);
        // X start equal to end.
        2: program_calibration(16'd2000, 16'd2000, 16'd100, 16'd3900,
                               16'd1, 16'd1, 16'd0, 16'd65535);
        // Y start equal to end, and a window that no pressure can fall in.
        3: program_calibration(16'd100, 16'd3900, 16'd0, 16'd0,
                               16'd1, 16'd1024, 16'd65535, 16'd0);
        // Zero columns and a row count beyond the field width.
        4: program_calibration(16'd4095, 16'd0, 16'd0, 16'd4095,
                               16'd0, 16'd2047, 16'd0, 16'd65535);
        // Every data bit set.
        5: program_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Back to the power-on calibration.
        PHASE_COUNT: program_calibration(16'(X_RAW_START_RST), 16'(X_RAW_END_RST),
                                         16'(Y_RAW_START_RST), 16'(Y_RAW_END_RST),
                                         16'(COLUMN_COUNT_RST), 16'(ROW_COUNT_RST),
                                         PRESSURE_LOW_RST, PRESSURE_HIGH_RST);
        // Random calibration, with stray bits above each register's width.
        default: begin
          floor_p = $urandom_range(150);
          program_calibration(with_junk($urandom_range(4095), 12),
                              with_junk($urandom_range(4095), 12),
                              with_junk($urandom_range(4095), 12),
                              with_junk($urandom_range(4095), 12),
                              with_junk($urandom_range(1, 1024), 11),
                              with_junk($urandom_range(1, 1024), 11),
                              16'(floor_p), 16'(floor_p + $urandom_range(1, 3000)));
        end
      endcase
      repeat (PHASE_GROUPS) send_random_group();
      settle();
    end

    $display("Run summary: %0d sample beats, %0d reports checked, %0d of them touches.",
             board.samples_seen, board.reports_seen, board.touches_expected);
    $display("Calibration settings used: %0d; mismatches: %0d.",
             settings_applied + 1, board.errors);
    if (board.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== touch_pressure_calibrate_unit.f =====
rtl/tpc_pkg.sv
rtl/tpc_divider.sv
rtl/tpc_datapath.sv
rtl/tpc_controller.sv
rtl/touch_pressure_calibrate_unit.sv
rtl/tpc_checker.sv
dv/tb_touch_pressure_calibrate_unit.sv
